// File: hw/rtl/positional_array_list_core_macros.svh
// Assertion macros for the positional array list core.
// Used by the controller; needs a clock and an active-low reset name per use.
`ifndef POSITIONAL_ARRAY_LIST_CORE_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_CORE_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define PAL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: invariant violated");

// Check an implication at every clock edge outside reset.
`define PAL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("%m: implication violated");

`endif

// File: hw/rtl/pal_pkg.sv
// Shared types and constants of the positional array list core.
// No dependencies; imported by every module of the block.
`default_nettype none

package pal_pkg;

  localparam int CAPACITY = 8;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LEN_W    = 4;
  localparam int DATA_W   = 32;

  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_READ   = 3'd1,
    MODE_WRITE  = 3'd2,
    MODE_INSERT = 3'd3,
    MODE_REMOVE = 3'd4,
    MODE_SEARCH = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   data;
    logic [LEN_W-1:0]    fpos;
    logic [LEN_W-1:0]    length;
    logic                last;
  } res_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [DATA_W-1:0]  data;
  } mem_wr_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
  } mem_rd_t;

endpackage

`default_nettype wire

// File: hw/rtl/pal_ram.sv
// Entry store: one write port, one read port, registered read data.
// Depends on pal_pkg for depth, widths and port structs.
`default_nettype none

module pal_ram import pal_pkg::*; (
  input  wire                clk,
  input  wire mem_wr_t       wr,
  input  wire mem_rd_t       rd,
  output logic [DATA_W-1:0]  rd_data
);

  logic [DATA_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read data holds between reads
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pal_obuf.sv
// Result register between the controller and the output stream.
// Depends on pal_pkg for the result struct.
`default_nettype none

module pal_obuf import pal_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push_valid,
  input  wire res_t          push,
  output logic               push_ready,
  output logic               out_tvalid,
  input  wire                out_tready,
  output logic [39:0]        out_tdata,   // data[31:0], found_position[35:32], length[39:36]
  output logic [2:0]         out_tuser,   // status[2:0]
  output logic               out_tlast
);

  logic valid_r, valid_nxt;
  res_t res_r, res_nxt;

  assign push_ready = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (push_valid && push_ready) begin
      valid_nxt = 1'b1;
      res_nxt   = push;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.length, res_r.fpos, res_r.data};
  assign out_tuser  = res_r.status;
  assign out_tlast  = res_r.last;

endmodule

`default_nettype wire

// File: hw/rtl/pal_ctrl.sv
// Command sequencer: decodes commands, runs shift and search walks over the
// entry store and produces results. Depends on pal_pkg and the macro header.
`default_nettype none
`include "positional_array_list_core_macros.svh"

module pal_ctrl import pal_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cmd_valid,
  output logic               cmd_ready,
  input  wire mode_t         cmd_mode,
  input  wire [LEN_W-1:0]    cmd_pos,
  input  wire [DATA_W-1:0]   cmd_value,
  output mem_wr_t            mem_wr,
  output mem_rd_t            mem_rd,
  input  wire [DATA_W-1:0]   mem_rdata,
  output logic               push_valid,
  output res_t               push,
  input  wire                push_ready
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_SHIFT = 5'b00100,
    S_SCAN  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [LEN_W-1:0]    count_r, count_nxt;
  mode_t               mode_r, mode_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [DATA_W-1:0]   val_r, val_nxt;
  status_t             rstat_r, rstat_nxt;
  logic [DATA_W-1:0]   rdata_r, rdata_nxt;
  logic [LEN_W-1:0]    rfpos_r, rfpos_nxt;
  logic [IDX_W-1:0]    rd_addr_r, rd_addr_nxt;
  logic [IDX_W-1:0]    dst_r, dst_nxt;
  logic [LEN_W-1:0]    moves_r, moves_nxt;
  logic                pend_r, pend_nxt;
  logic [LEN_W-1:0]    scan_rd_r, scan_rd_nxt;
  logic [IDX_W-1:0]    scan_cmp_r, scan_cmp_nxt;
  logic                have_r, have_nxt;
  logic [LEN_W-1:0]    mpos_r, mpos_nxt;

  logic [IDX_W-1:0]    cmd_idx;
  logic                pos_bad;
  logic                ins_bad;
  logic                is_ins;
  logic                match;
  logic                consume;

  assign cmd_idx = IDX_W'(cmd_pos - LEN_W'(1));
  assign pos_bad = (cmd_pos == '0) || (cmd_pos > count_r);
  assign ins_bad = (cmd_pos == '0) ||
                   ({1'b0, cmd_pos} > ({1'b0, count_r} + (LEN_W+1)'(1)));
  assign is_ins  = (mode_r == MODE_INSERT);
  assign match   = pend_r && (mem_rdata == val_r);
  // a second match needs room in the result register before it is taken
  assign consume = pend_r && (!(match && have_r) || push_ready);
  assign cmd_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    mode_nxt     = mode_r;
    idx_nxt      = idx_r;
    val_nxt      = val_r;
    rstat_nxt    = rstat_r;
    rdata_nxt    = rdata_r;
    rfpos_nxt    = rfpos_r;
    rd_addr_nxt  = rd_addr_r;
    dst_nxt      = dst_r;
    moves_nxt    = moves_r;
    pend_nxt     = pend_r;
    scan_rd_nxt  = scan_rd_r;
    scan_cmp_nxt = scan_cmp_r;
    have_nxt     = have_r;
    mpos_nxt     = mpos_r;
    mem_wr       = '0;
    mem_rd       = '0;
    push_valid   = 1'b0;
    push         = '0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          mode_nxt  = cmd_mode;
          idx_nxt   = cmd_idx;
          val_nxt   = cmd_value;
          rstat_nxt = ST_OK;
          rdata_nxt = '0;
          rfpos_nxt = '0;
          pend_nxt  = 1'b0;
          case (cmd_mode)
            MODE_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_RESP;
            end
            MODE_READ, MODE_WRITE, MODE_REMOVE: begin
              if (count_r == '0) begin
                rstat_nxt = ST_EMPTY;
                state_nxt = S_RESP;
              end else if (pos_bad) begin
                rstat_nxt = ST_BADPOS;
                state_nxt = S_RESP;
              end else begin
                mem_rd.en   = 1'b1;
                mem_rd.addr = cmd_idx;
                state_nxt   = S_FETCH;
              end
            end
            MODE_INSERT: begin
              if (count_r >= LEN_W'(CAPACITY)) begin
                rstat_nxt = ST_FULL;
                state_nxt = S_RESP;
              end else if (ins_bad) begin
                rstat_nxt = ST_BADPOS;
                state_nxt = S_RESP;
              end else if (cmd_pos == count_r + LEN_W'(1)) begin
                // append: nothing to move
                mem_wr.en   = 1'b1;
                mem_wr.addr = cmd_idx;
                mem_wr.data = cmd_value;
                count_nxt   = count_r + LEN_W'(1);
                state_nxt   = S_RESP;
              end else begin
                rd_addr_nxt = IDX_W'(count_r - LEN_W'(1));
                moves_nxt   = count_r - LEN_W'(cmd_idx);
                state_nxt   = S_SHIFT;
              end
            end
            MODE_SEARCH: begin
              if (count_r == '0) begin
                rstat_nxt = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                scan_rd_nxt = '0;
                have_nxt    = 1'b0;
                state_nxt   = S_SCAN;
              end
            end
            default: begin
              // unused modes: drop the transaction
            end
          endcase
        end
      end

      S_FETCH: begin
        rdata_nxt = mem_rdata;
        case (mode_r)
          MODE_WRITE: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = idx_r;
            mem_wr.data = val_r;
            state_nxt   = S_RESP;
          end
          MODE_REMOVE: begin
            if (LEN_W'(idx_r) + LEN_W'(1) == count_r) begin
              count_nxt = count_r - LEN_W'(1);
              state_nxt = S_RESP;
            end else begin
              rd_addr_nxt = idx_r + IDX_W'(1);
              moves_nxt   = count_r - LEN_W'(idx_r) - LEN_W'(1);
              state_nxt   = S_SHIFT;
            end
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end

      S_SHIFT: begin
        // write back the word read last cycle while reading the next one
        if (pend_r) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = dst_r;
          mem_wr.data = mem_rdata;
        end
        if (moves_r != '0) begin
          mem_rd.en   = 1'b1;
          mem_rd.addr = rd_addr_r;
          dst_nxt     = is_ins ? rd_addr_r + IDX_W'(1) : rd_addr_r - IDX_W'(1);
          rd_addr_nxt = is_ins ? rd_addr_r - IDX_W'(1) : rd_addr_r + IDX_W'(1);
          moves_nxt   = moves_r - LEN_W'(1);
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (is_ins) begin
              mem_wr.en   = 1'b1;
              mem_wr.addr = idx_r;
              mem_wr.data = val_r;
              count_nxt   = count_r + LEN_W'(1);
            end else begin
              count_nxt = count_r - LEN_W'(1);
            end
            state_nxt = S_RESP;
          end
        end
      end

      S_SCAN: begin
        if (consume && match) begin
          if (have_r) begin
            push_valid  = 1'b1;
            push.status = ST_OK;
            push.fpos   = mpos_r;
            push.length = count_r;
            push.last   = 1'b0;
          end
          mpos_nxt = LEN_W'(scan_cmp_r) + LEN_W'(1);
          have_nxt = 1'b1;
        end
        if (!pend_r || consume) begin
          if (scan_rd_r < count_r) begin
            mem_rd.en    = 1'b1;
            mem_rd.addr  = IDX_W'(scan_rd_r);
            scan_cmp_nxt = IDX_W'(scan_rd_r);
            scan_rd_nxt  = scan_rd_r + LEN_W'(1);
            pend_nxt     = 1'b1;
          end else begin
            pend_nxt = 1'b0;
            if (!pend_r) begin
              rstat_nxt = have_r ? ST_OK : ST_NOTFOUND;
              rfpos_nxt = have_r ? mpos_r : '0;
              state_nxt = S_RESP;
            end
          end
        end
      end

      S_RESP: begin
        if (push_ready) begin
          push_valid  = 1'b1;
          push.status = rstat_r;
          push.data   = rdata_r;
          push.fpos   = rfpos_r;
          push.length = count_r;
          push.last   = 1'b1;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      have_r  <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    rstat_r    <= rstat_nxt;
    rdata_r    <= rdata_nxt;
    rfpos_r    <= rfpos_nxt;
    rd_addr_r  <= rd_addr_nxt;
    dst_r      <= dst_nxt;
    moves_r    <= moves_nxt;
    scan_rd_r  <= scan_rd_nxt;
    scan_cmp_r <= scan_cmp_nxt;
    mpos_r     <= mpos_nxt;
  end

  `PAL_ASSERT(a_count_bound, clk, rst_n, count_r <= LEN_W'(CAPACITY))
  `PAL_ASSERT_IMP(a_no_collide, clk, rst_n, mem_wr.en && mem_rd.en, mem_wr.addr != mem_rd.addr)
  `PAL_ASSERT_IMP(a_push_room, clk, rst_n, push_valid, push_ready)
  `PAL_ASSERT_IMP(a_resp_done, clk, rst_n, (state_r == S_RESP) && push_ready, ##1 (state_r == S_IDLE))

endmodule

`default_nettype wire

// File: hw/rtl/positional_array_list_core.sv
// Path to result register: clear, rejected commands and append go straight to response;
// read, write and remove of the last entry pass fetch; other removes fetch, then shift;
// insert shifts; search scans every entry, earlier matches leave once the next is seen.
// Throughput: one command at a time, set by the single port pair of the entry store;
// the next command is taken the cycle after the last result enters the output register.
// Reset: clears the entry count and the output valid flag; entries stay undefined.
`default_nettype none

module positional_array_list_core import pal_pkg::*; (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [39:0]  in_tdata,   // position[3:0], value[35:4], zero[39:36]
  input  wire  [2:0]   in_tuser,   // mode[2:0]
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [39:0]  out_tdata,  // data[31:0], found_position[35:32], length[39:36]
  output logic [2:0]   out_tuser,  // status[2:0]
  output logic         out_tlast
);

  mem_wr_t            mem_wr;
  mem_rd_t            mem_rd;
  logic [DATA_W-1:0]  mem_rdata;
  logic               push_valid;
  logic               push_ready;
  res_t               push;

  pal_ram u_ram (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (mem_rdata)
  );

  pal_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (in_tvalid),
    .cmd_ready  (in_tready),
    .cmd_mode   (mode_t'(in_tuser)),
    .cmd_pos    (in_tdata[3:0]),
    .cmd_value  (in_tdata[35:4]),
    .mem_wr     (mem_wr),
    .mem_rd     (mem_rd),
    .mem_rdata  (mem_rdata),
    .push_valid (push_valid),
    .push       (push),
    .push_ready (push_ready)
  );

  pal_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push       (push),
    .push_ready (push_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
